@@ rtl/soa_pkg.sv @@
// Package for the sphere overlap scan table.
// Holds the field widths, codes and shared types. Depends on nothing.
package soa_pkg;

  localparam int unsigned MaxSpheresDefault = 64;
  localparam int unsigned CoordW  = 24;
  localparam int unsigned RadW    = 23;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned StatusW = 2;

  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOMATCH = 2'd1,
    STATUS_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [RadW-1:0]          r;
  } sphere_t;

  typedef struct packed {
    logic            vld;
    logic            elig;
    logic            fin;
    logic [IdxW-1:0] idx;
  } scan_tag_t;

endpackage

@@ rtl/soa_if.sv @@
// Channel interfaces for the sphere overlap scan table.
// Depends on soa_pkg for field widths.
interface soa_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   func;
  logic signed [soa_pkg::CoordW-1:0]      center_x;
  logic signed [soa_pkg::CoordW-1:0]      center_y;
  logic signed [soa_pkg::CoordW-1:0]      center_z;
  logic [soa_pkg::RadW-1:0]               radius;

  modport source (output valid, func, center_x, center_y, center_z, radius, input ready);
  modport sink   (input valid, func, center_x, center_y, center_z, radius, output ready);
endinterface

interface soa_out_if;
  logic                          valid;
  logic                          ready;
  logic [soa_pkg::IdxW-1:0]      entry_index;
  logic [soa_pkg::StatusW-1:0]   status;
  logic                          last;

  modport source (output valid, entry_index, status, last, input ready);
  modport sink   (input valid, entry_index, status, last, output ready);
endinterface

@@ rtl/soa_cell.sv @@
// One storage cell of the sphere ring: holds one table entry.
// Depends on soa_pkg for the sphere type.
module soa_cell (
  input  logic             clk_i,
  input  logic             shift_i,
  input  logic             wr_i,
  input  soa_pkg::sphere_t wr_data_i,
  input  soa_pkg::sphere_t nbr_i,
  output soa_pkg::sphere_t data_o
);
  import soa_pkg::*;

  sphere_t data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      data_q <= wr_data_i;
    end else if (shift_i) begin
      data_q <= nbr_i;
    end
  end

  assign data_o = data_q;

endmodule

@@ rtl/soa_dist_unit.sv @@
// Three-stage overlap test of one stored sphere against the query sphere.
// Depends on soa_pkg for the sphere and tag types.
module soa_dist_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  soa_pkg::scan_tag_t tag_i,
  input  soa_pkg::sphere_t   query_i,
  input  soa_pkg::sphere_t   entry_i,
  output soa_pkg::scan_tag_t tag_o,
  output logic               hit_o
);
  import soa_pkg::*;

  localparam int unsigned DiffW = CoordW + 1;
  localparam int unsigned SqW   = 2 * DiffW;
  localparam int unsigned DsumW = SqW + 2;
  localparam int unsigned RsumW = RadW + 1;
  localparam int unsigned RsqW  = 2 * RsumW;

  scan_tag_t tag1_q, tag2_q, tag3_q;
  logic [DiffW-1:0] ax_q, ay_q, az_q;
  logic [RsumW-1:0] rsum_q;
  logic [SqW-1:0]   sx_q, sy_q, sz_q;
  logic [RsqW-1:0]  rsq_q;
  logic             hit_q;

  logic signed [DiffW-1:0] dx, dy, dz;
  logic [DsumW-1:0]        dsq;

  assign dx = {entry_i.x[CoordW-1], entry_i.x} - {query_i.x[CoordW-1], query_i.x};
  assign dy = {entry_i.y[CoordW-1], entry_i.y} - {query_i.y[CoordW-1], query_i.y};
  assign dz = {entry_i.z[CoordW-1], entry_i.z} - {query_i.z[CoordW-1], query_i.z};
  assign dsq = DsumW'(sx_q) + DsumW'(sy_q) + DsumW'(sz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (en_i) begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ax_q   <= dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
      ay_q   <= dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
      az_q   <= dz[DiffW-1] ? DiffW'(-dz) : DiffW'(dz);
      rsum_q <= RsumW'(entry_i.r) + RsumW'(query_i.r);
      sx_q   <= SqW'(ax_q) * SqW'(ax_q);
      sy_q   <= SqW'(ay_q) * SqW'(ay_q);
      sz_q   <= SqW'(az_q) * SqW'(az_q);
      rsq_q  <= RsqW'(rsum_q) * RsqW'(rsum_q);
      hit_q  <= tag2_q.elig && (dsq <= DsumW'(rsq_q));
    end
  end

  assign tag_o = tag3_q;
  assign hit_o = hit_q;

endmodule

@@ rtl/sphere_overlap_scan_table.sv @@
// Sphere overlap scan table, top level. An add answers in the cycle after
// its transfer with the new index or a full status. A query rotates the ring
// of MAX_SPHERES cells past a single three-stage distance unit, one entry per
// cycle while no result waits on the output, and it holds the input side
// until it has issued its last result. Depends on soa_pkg, soa_if, soa_cell
// and soa_dist_unit.
module sphere_overlap_scan_table #(
  parameter int unsigned MAX_SPHERES = soa_pkg::MaxSpheresDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  soa_in_if.sink    req_i,
  soa_out_if.source rsp_o
);
  import soa_pkg::*;

  localparam int unsigned CntW  = $clog2(MAX_SPHERES + 1);
  localparam int unsigned ScanW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [ScanW-1:0] scan_q, scan_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  sphere_t         query_q;

  logic             out_valid_q;
  logic [IdxW-1:0]  out_idx_q;
  status_e          out_status_q;
  logic             out_last_q;

  logic             wr_out;
  logic [IdxW-1:0]  wr_idx;
  status_e          wr_status;
  logic             wr_last;

  logic      adv, accept, is_add, full, shift;
  scan_tag_t issue_tag, res_tag;
  logic      res_hit;
  sphere_t   req_sphere;
  sphere_t   cell_q [MAX_SPHERES];

  assign adv    = !out_valid_q || rsp_o.ready;
  assign req_i.ready = (state_q == ST_IDLE) && adv;
  assign accept = req_i.valid && req_i.ready;
  assign is_add = (req_i.func == FUNC_ADD);
  assign full   = (count_q >= CntW'(MAX_SPHERES));
  assign shift  = (state_q == ST_SCAN) && adv;

  assign req_sphere.x = req_i.center_x;
  assign req_sphere.y = req_i.center_y;
  assign req_sphere.z = req_i.center_z;
  assign req_sphere.r = req_i.radius;

  for (genvar i = 0; i < MAX_SPHERES; i++) begin : g_cell
    localparam int unsigned Nbr = (i + 1) % MAX_SPHERES;
    soa_cell u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .wr_i     (accept && is_add && !full && (count_q == CntW'(i))),
      .wr_data_i(req_sphere),
      .nbr_i    (cell_q[Nbr]),
      .data_o   (cell_q[i])
    );
  end

  always_comb begin
    issue_tag      = '0;
    issue_tag.vld  = (state_q == ST_SCAN);
    issue_tag.elig = (CntW'(scan_q) < count_q);
    issue_tag.fin  = (scan_q == ScanW'(MAX_SPHERES - 1));
    issue_tag.idx  = IdxW'(scan_q);
  end

  soa_dist_unit u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .tag_i  (issue_tag),
    .query_i(query_q),
    .entry_i(cell_q[0]),
    .tag_o  (res_tag),
    .hit_o  (res_hit)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_d     = scan_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    wr_out     = 1'b0;
    wr_idx     = '0;
    wr_status  = STATUS_OK;
    wr_last    = 1'b0;
    if (adv) begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (is_add) begin
              wr_out  = 1'b1;
              wr_last = 1'b1;
              if (full) begin
                wr_status = STATUS_FULL;
              end else begin
                wr_idx  = IdxW'(count_q);
                count_d = count_q + CntW'(1);
              end
            end else begin
              scan_d  = '0;
              pend_d  = 1'b0;
              state_d = ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          scan_d = scan_q + ScanW'(1);
          if (issue_tag.fin) begin
            state_d = ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (res_tag.vld && res_tag.fin) begin
            state_d = ST_FINISH;
          end
        end
        ST_FINISH: begin
          wr_out    = 1'b1;
          wr_last   = 1'b1;
          wr_idx    = pend_q ? pend_idx_q : '0;
          wr_status = pend_q ? STATUS_OK : STATUS_NOMATCH;
          pend_d    = 1'b0;
          state_d   = ST_IDLE;
        end
        default: state_d = ST_IDLE;
      endcase
      if (res_tag.vld && res_hit) begin
        if (pend_q) begin
          wr_out = 1'b1;
          wr_idx = pend_idx_q;
        end
        pend_d     = 1'b1;
        pend_idx_d = res_tag.idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
      if (adv) begin
        out_valid_q <= wr_out;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    if (accept && !is_add) begin
      query_q <= req_sphere;
    end
    if (adv && wr_out) begin
      out_idx_q    <= wr_idx;
      out_status_q <= wr_status;
      out_last_q   <= wr_last;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.entry_index = out_idx_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.last        = out_last_q;

endmodule

@@ rtl/soa_checker.sv @@
// Port-level checks for the sphere overlap scan table, bound to the top level.
// Depends on soa_pkg for the function and status codes.
module soa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       in_func_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [soa_pkg::IdxW-1:0]   out_index_i,
  input logic [soa_pkg::StatusW-1:0] out_status_i,
  input logic                       out_last_i
);
  import soa_pkg::*;

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != STATUS_OK) |-> out_last_i)
    else $error("non-ok status without last");

  a_add_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == FUNC_ADD) |=> out_valid_i && out_last_i)
    else $error("add transfer without an immediate single result");

  a_query_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_func_i == FUNC_QUERY) |=> !in_ready_i)
    else $error("input ready during a query scan");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_index_i) && $stable(out_status_i) && $stable(out_last_i))
    else $error("stalled result changed");

endmodule

bind sphere_overlap_scan_table soa_checker u_soa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_func_i   (req_i.func),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_index_i (rsp_o.entry_index),
  .out_status_i(rsp_o.status),
  .out_last_i  (rsp_o.last)
);
